[hw/rtl/mvs_pkg.sv]
`timescale 1ns / 1ps
package mvs_pkg;

  localparam int MAX_VERSIONS = 8;
  localparam int ADDR_W       = (MAX_VERSIONS > 1) ? $clog2(MAX_VERSIONS) : 1;
  localparam int CNT_W        = $clog2(MAX_VERSIONS + 1);
  localparam int DATA_W       = 64;

  typedef enum logic [1:0] {
    MODE_APPEND = 2'd0,
    MODE_MARK   = 2'd1,
    MODE_READ   = 2'd2,
    MODE_PRUNE  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_EMPTY   = 2'd2,
    STAT_DELETED = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_APPEND,
    S_FETCH,
    S_CHECK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]        mode;
    logic [DATA_W-1:0] value_handle;
    logic [DATA_W-1:0] stamp;
  } request_t;

  typedef struct packed {
    logic              found;
    logic [DATA_W-1:0] read_value;
    logic [1:0]        status;
    logic              head_live;
    logic [3:0]        version_count;
  } result_t;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic [DATA_W-1:0] created;
    logic [DATA_W-1:0] deleted;
  } entry_t;

  typedef struct packed {
    logic visible;
    logic expired;
  } match_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Map a list position to a RAM slot of the circular buffer.
  function automatic logic [ADDR_W-1:0] phys_addr(input logic [ADDR_W-1:0] head,
                                                  input logic [CNT_W-1:0]  off);
    logic [CNT_W:0] sum;
    sum = (CNT_W + 1)'(head) + (CNT_W + 1)'(off);
    if (sum >= (CNT_W + 1)'(MAX_VERSIONS)) begin
      sum = sum - (CNT_W + 1)'(MAX_VERSIONS);
    end
    return ADDR_W'(sum);
  endfunction

endpackage

[hw/rtl/mvs_ram.sv]
`timescale 1ns / 1ps
module mvs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/mvs_match.sv]
`timescale 1ns / 1ps
module mvs_match (
  input  logic [mvs_pkg::DATA_W-1:0] created,
  input  logic [mvs_pkg::DATA_W-1:0] deleted,
  input  logic [mvs_pkg::DATA_W-1:0] key,
  output mvs_pkg::match_t            match
);
  import mvs_pkg::*;

  logic del_zero;
  logic del_le_key;

  assign del_zero   = (deleted == '0);
  assign del_le_key = (deleted <= key);

  // Visible at a snapshot: created by then and not yet deleted.
  assign match.visible = (created <= key) && (del_zero || !del_le_key);
  // Reclaimable at a safe stamp: deleted at or before it.
  assign match.expired = !del_zero && del_le_key;

endmodule

[hw/rtl/mvcc_version_store.sv]
// Sequencing: append runs S_APPEND then S_DONE; mark deleted S_FETCH, S_CHECK, S_DONE; read
//   and prune run S_FETCH and S_CHECK per entry walked, at most MAX_VERSIONS entries.
// Throughput: one request at a time; the next is taken the cycle after done.
//   The walk rate is set by the single RAM read port and the shared compare unit.
// Reset clears the version count, head pointer and sequencer; the version RAM is
//   not cleared. Results are shown for one cycle on done; the receiver cannot stall.
`timescale 1ns / 1ps
module mvcc_version_store (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  mvs_pkg::request_t request,
  output logic              done,
  output mvs_pkg::result_t  result
);
  import mvs_pkg::*;

  state_t                state, state_next;
  request_t              req_q, req_q_next;
  logic [CNT_W-1:0]      idx, idx_next;
  logic [CNT_W-1:0]      wcnt, wcnt_next;
  logic [CNT_W-1:0]      count, count_next;
  logic [ADDR_W-1:0]     head, head_next;
  logic                  head_live, head_live_next;
  logic                  found_q, found_q_next;
  logic [DATA_W-1:0]     value_q, value_q_next;
  status_t               status_q, status_q_next;

  logic                  accept;
  logic                  ram_we, ram_re;
  logic [ADDR_W-1:0]     ram_waddr, ram_raddr;
  entry_t                ram_wdata, ram_rdata;
  match_t                match;
  logic [CNT_W-1:0]      idx_inc;
  logic [CNT_W-1:0]      kept_cnt;
  logic                  last;
  logic [ADDR_W-1:0]     head_dec;
  logic                  full;

  assign accept   = start && !busy;
  assign idx_inc  = idx + 1'b1;
  assign last     = (idx_inc == count);
  assign kept_cnt = wcnt + (match.expired ? CNT_W'(0) : CNT_W'(1));
  assign head_dec = (head == '0) ? ADDR_W'(MAX_VERSIONS - 1) : head - 1'b1;
  assign full     = (count == CNT_W'(MAX_VERSIONS));

  mvs_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_VERSIONS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  mvs_match u_match (
    .created (ram_rdata.created),
    .deleted (ram_rdata.deleted),
    .key     (req_q.stamp),
    .match   (match)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (mode_t'(request.mode))
            MODE_APPEND: state_next = full ? S_DONE : S_APPEND;
            MODE_MARK:   state_next = (count == '0 || !head_live) ? S_DONE : S_FETCH;
            default:     state_next = (count == '0) ? S_DONE : S_FETCH;
          endcase
        end
      end
      S_APPEND: state_next = S_DONE;
      S_FETCH:  state_next = S_CHECK;
      S_CHECK: begin
        case (mode_t'(req_q.mode))
          MODE_READ:  state_next = (match.visible || last) ? S_DONE : S_FETCH;
          MODE_PRUNE: state_next = last ? S_DONE : S_FETCH;
          default:    state_next = S_DONE;
        endcase
      end
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Datapath and RAM control
  always_comb begin
    req_q_next     = req_q;
    idx_next       = idx;
    wcnt_next      = wcnt;
    count_next     = count;
    head_next      = head;
    head_live_next = head_live;
    found_q_next   = found_q;
    value_q_next   = value_q;
    status_q_next  = status_q;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    ram_waddr      = phys_addr(head, wcnt);
    ram_raddr      = phys_addr(head, idx);
    ram_wdata      = ram_rdata;
    case (state)
      S_IDLE: begin
        if (accept) begin
          req_q_next    = request;
          idx_next      = '0;
          wcnt_next     = '0;
          found_q_next  = 1'b0;
          value_q_next  = '0;
          status_q_next = STAT_OK;
          case (mode_t'(request.mode))
            MODE_APPEND: begin
              if (full) status_q_next = STAT_FULL;
            end
            MODE_MARK: begin
              if (count == '0) begin
                status_q_next = STAT_EMPTY;
              end else if (!head_live) begin
                status_q_next = STAT_DELETED;
              end
            end
            default: ;
          endcase
        end
      end
      S_APPEND: begin
        // Push at the head: step the pointer back and write the new live version.
        ram_we            = 1'b1;
        ram_waddr         = head_dec;
        ram_wdata.value   = req_q.value_handle;
        ram_wdata.created = req_q.stamp;
        ram_wdata.deleted = '0;
        head_next         = head_dec;
        count_next        = count + 1'b1;
        head_live_next    = 1'b1;
      end
      S_FETCH: ram_re = 1'b1;
      S_CHECK: begin
        case (mode_t'(req_q.mode))
          MODE_MARK: begin
            ram_we            = 1'b1;
            ram_waddr         = head;
            ram_wdata.deleted = req_q.stamp;
            head_live_next    = (req_q.stamp == '0);
          end
          MODE_READ: begin
            if (match.visible) begin
              found_q_next = 1'b1;
              value_q_next = ram_rdata.value;
            end
            idx_next = idx_inc;
          end
          MODE_PRUNE: begin
            // Compact survivors toward the head; writes never pass the read point.
            if (!match.expired) begin
              ram_we    = 1'b1;
              wcnt_next = kept_cnt;
              if (wcnt == '0) head_live_next = (ram_rdata.deleted == '0);
            end
            idx_next = idx_inc;
            if (last) begin
              count_next = kept_cnt;
              if (kept_cnt == '0) head_live_next = 1'b0;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      head      <= '0;
      head_live <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      head      <= head_next;
      head_live <= head_live_next;
    end
  end

  always_ff @(posedge clk) begin
    req_q    <= req_q_next;
    idx      <= idx_next;
    wcnt     <= wcnt_next;
    found_q  <= found_q_next;
    value_q  <= value_q_next;
    status_q <= status_q_next;
  end

  assign busy                 = (state != S_IDLE);
  assign done                 = (state == S_DONE);
  assign result.found         = found_q;
  assign result.read_value    = value_q;
  assign result.status        = status_q;
  assign result.head_live     = head_live;
  assign result.version_count = 4'(count);

endmodule

[hw/rtl/mvs_checker.sv]
`timescale 1ns / 1ps
module mvs_checker (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             done,
  input mvs_pkg::result_t result
);
  import mvs_pkg::*;

  // A taken request holds the block until its result is out.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("request taken but block not busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held longer than one cycle");

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    done && result.found |-> result.status == STAT_OK)
    else $error("read hit reported with an error status");

  a_live_nonempty: assert property (@(posedge clk) disable iff (rst)
    done && result.head_live |-> (MAX_VERSIONS >= 16) || (result.version_count != 4'd0))
    else $error("live head reported on an empty list");

endmodule

bind mvcc_version_store mvs_checker u_mvs_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
